>>> design/fpc_pkg.sv
// Shared types, constants and register codes for the fader position conditioner.
`timescale 1ns / 1ps

package fpc_pkg;

    // Default configuration of the top-level parameters.
    localparam int FADER_SLOTS_DEF = 8;
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed field widths.
    localparam int IDX_W  = 3;
    localparam int SMP_W  = 12;
    localparam int POS_W  = 12;
    localparam int ACT_W  = 4;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int REG_W  = 3;

    // Register indexes (byte address is four times the index).
    localparam logic [REG_W-1:0] REG_TRAVEL_LO       = 3'd0;
    localparam logic [REG_W-1:0] REG_TRAVEL_HI       = 3'd1;
    localparam logic [REG_W-1:0] REG_SNAP_LOW_LEVEL  = 3'd2;
    localparam logic [REG_W-1:0] REG_SNAP_HIGH_LEVEL = 3'd3;
    localparam logic [REG_W-1:0] REG_DEADBAND_WIDTH  = 3'd4;
    localparam logic [REG_W-1:0] REG_ACTIVE_FADERS   = 3'd5;

    // Reset values of the registers.
    localparam logic [SMP_W-1:0] RST_TRAVEL_LO       = 12'd0;
    localparam logic [SMP_W-1:0] RST_TRAVEL_HI       = 12'd4095;
    localparam logic [SMP_W-1:0] RST_SNAP_LOW_LEVEL  = 12'd0;
    localparam logic [SMP_W-1:0] RST_SNAP_HIGH_LEVEL = 12'd4095;
    localparam logic [SMP_W-1:0] RST_DEADBAND_WIDTH  = 12'd0;
    localparam logic [ACT_W-1:0] RST_ACTIVE_FADERS   = 4'd1;

    typedef struct packed {
        logic [SMP_W-1:0] travel_lo;
        logic [SMP_W-1:0] travel_hi;
        logic [SMP_W-1:0] snap_low_level;
        logic [SMP_W-1:0] snap_high_level;
        logic [SMP_W-1:0] deadband_width;
        logic [ACT_W-1:0] active_faders;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIVIDE,
        S_SNAP,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic capture;
        logic prep;
        logic step;
        logic snap;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic in_active;
        logic out_free;
    } t_dp_status;

endpackage

>>> design/fpc_regs.sv
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps

module fpc_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fpc_pkg::ADDR_W-1:0] paddr,
    input  logic [fpc_pkg::DATA_W-1:0] pwdata,
    output logic [fpc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output fpc_pkg::t_cfg              o_cfg
);

    fpc_pkg::t_cfg               r_cfg;
    logic [fpc_pkg::REG_W-1:0]   reg_idx;
    logic                        wr_en;

    assign reg_idx = paddr[fpc_pkg::ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.travel_lo       <= fpc_pkg::RST_TRAVEL_LO;
            r_cfg.travel_hi       <= fpc_pkg::RST_TRAVEL_HI;
            r_cfg.snap_low_level  <= fpc_pkg::RST_SNAP_LOW_LEVEL;
            r_cfg.snap_high_level <= fpc_pkg::RST_SNAP_HIGH_LEVEL;
            r_cfg.deadband_width  <= fpc_pkg::RST_DEADBAND_WIDTH;
            r_cfg.active_faders   <= fpc_pkg::RST_ACTIVE_FADERS;
        end else if (wr_en) begin
            case (reg_idx)
                fpc_pkg::REG_TRAVEL_LO:       r_cfg.travel_lo       <= pwdata[fpc_pkg::SMP_W-1:0];
                fpc_pkg::REG_TRAVEL_HI:       r_cfg.travel_hi       <= pwdata[fpc_pkg::SMP_W-1:0];
                fpc_pkg::REG_SNAP_LOW_LEVEL:  r_cfg.snap_low_level  <= pwdata[fpc_pkg::SMP_W-1:0];
                fpc_pkg::REG_SNAP_HIGH_LEVEL: r_cfg.snap_high_level <= pwdata[fpc_pkg::SMP_W-1:0];
                fpc_pkg::REG_DEADBAND_WIDTH:  r_cfg.deadband_width  <= pwdata[fpc_pkg::SMP_W-1:0];
                fpc_pkg::REG_ACTIVE_FADERS:   r_cfg.active_faders   <= pwdata[fpc_pkg::ACT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            fpc_pkg::REG_TRAVEL_LO:       prdata = fpc_pkg::DATA_W'(r_cfg.travel_lo);
            fpc_pkg::REG_TRAVEL_HI:       prdata = fpc_pkg::DATA_W'(r_cfg.travel_hi);
            fpc_pkg::REG_SNAP_LOW_LEVEL:  prdata = fpc_pkg::DATA_W'(r_cfg.snap_low_level);
            fpc_pkg::REG_SNAP_HIGH_LEVEL: prdata = fpc_pkg::DATA_W'(r_cfg.snap_high_level);
            fpc_pkg::REG_DEADBAND_WIDTH:  prdata = fpc_pkg::DATA_W'(r_cfg.deadband_width);
            fpc_pkg::REG_ACTIVE_FADERS:   prdata = fpc_pkg::DATA_W'(r_cfg.active_faders);
            default:                      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/fpc_ctrl.sv
// Sequencing state machine for one fader transaction at a time.
`timescale 1ns / 1ps

module fpc_ctrl #(
    parameter int SAMPLE_BITS = fpc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fpc_pkg::t_dp_status i_status,
    output fpc_pkg::t_dp_cmd    o_cmd
);

    localparam int CNT_W = $clog2(SAMPLE_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_BITS - 1);

    fpc_pkg::t_state r_state;
    fpc_pkg::t_state n_state;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpc_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == fpc_pkg::S_DIVIDE) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fpc_pkg::S_IDLE: begin
                if (i_in_valid && i_status.in_active) begin
                    n_state = fpc_pkg::S_PREP;
                end
            end
            fpc_pkg::S_PREP: begin
                n_state = fpc_pkg::S_DIVIDE;
            end
            fpc_pkg::S_DIVIDE: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = fpc_pkg::S_SNAP;
                end
            end
            fpc_pkg::S_SNAP: begin
                n_state = fpc_pkg::S_UPDATE;
            end
            fpc_pkg::S_UPDATE: begin
                if (i_status.out_free) begin
                    n_state = fpc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fpc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            fpc_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid && i_status.in_active;
            end
            fpc_pkg::S_PREP:   o_cmd.prep = 1'b1;
            fpc_pkg::S_DIVIDE: o_cmd.step = 1'b1;
            fpc_pkg::S_SNAP:   o_cmd.snap = 1'b1;
            fpc_pkg::S_UPDATE: o_cmd.update = i_status.out_free;
            default: ;
        endcase
    end

endmodule

>>> design/fpc_datapath.sv
// Clamp, rescale divider, snap, deadband, position store and output register.
`timescale 1ns / 1ps

module fpc_datapath #(
    parameter int FADER_SLOTS = fpc_pkg::FADER_SLOTS_DEF,
    parameter int SAMPLE_BITS = fpc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  fpc_pkg::t_dp_cmd          i_cmd,
    output fpc_pkg::t_dp_status       o_status,
    input  fpc_pkg::t_cfg             i_cfg,
    input  logic [fpc_pkg::IDX_W-1:0] i_fader_index,
    input  logic [fpc_pkg::SMP_W-1:0] i_filtered_sample,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [fpc_pkg::IDX_W-1:0] o_out_fader_index,
    output logic [fpc_pkg::POS_W-1:0] o_position
);

    localparam int SLOT_AW = (FADER_SLOTS > 1) ? $clog2(FADER_SLOTS) : 1;
    localparam int NUM_W   = fpc_pkg::SMP_W + SAMPLE_BITS;
    localparam int CMP_W   = ((SAMPLE_BITS > fpc_pkg::POS_W) ? SAMPLE_BITS : fpc_pkg::POS_W) + 1;
    localparam logic [CMP_W-1:0] FULL_SCALE = CMP_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    logic [fpc_pkg::IDX_W-1:0] r_idx;
    logic [fpc_pkg::SMP_W-1:0] r_sample;
    logic [fpc_pkg::SMP_W-1:0] r_rem;
    logic [SAMPLE_BITS-1:0]    r_div;
    logic [fpc_pkg::SMP_W-1:0] r_span;
    logic                      r_empty;
    logic [fpc_pkg::POS_W-1:0] r_old;
    logic [CMP_W-1:0]          r_v;
    logic [fpc_pkg::POS_W-1:0] r_mem [FADER_SLOTS];
    logic [FADER_SLOTS-1:0]    r_slot_valid;
    logic                      r_out_valid;
    logic [fpc_pkg::IDX_W-1:0] r_out_idx;
    logic [fpc_pkg::POS_W-1:0] r_out_pos;

    logic [SLOT_AW-1:0]        slot;
    logic [fpc_pkg::SMP_W-1:0] clamped;
    logic [fpc_pkg::SMP_W-1:0] offset;
    logic [NUM_W-1:0]          num;
    logic [fpc_pkg::SMP_W:0]   trial;
    logic                      trial_ge;
    logic [CMP_W-1:0]          quot;
    logic [CMP_W-1:0]          n_v;
    logic [CMP_W-1:0]          old_w;
    logic [CMP_W-1:0]          delta;
    logic [fpc_pkg::POS_W-1:0] n_pos;

    assign o_status.in_active =
        (fpc_pkg::ACT_W'(i_fader_index) < i_cfg.active_faders) &&
        (32'(i_fader_index) < FADER_SLOTS);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign slot = SLOT_AW'(r_idx);

    // Clamp to the usable travel and scale by full scale (shift and subtract).
    always_comb begin
        clamped = r_sample;
        if (r_sample < i_cfg.travel_lo) begin
            clamped = i_cfg.travel_lo;
        end else if (r_sample > i_cfg.travel_hi) begin
            clamped = i_cfg.travel_hi;
        end
        offset = clamped - i_cfg.travel_lo;
        num    = {offset, {SAMPLE_BITS{1'b0}}} - NUM_W'(offset);
    end

    // One restoring division step; the quotient shifts in behind the dividend.
    assign trial    = {r_rem, r_div[SAMPLE_BITS-1]};
    assign trial_ge = trial >= {1'b0, r_span};

    always_comb begin
        quot = r_empty ? '0 : CMP_W'(r_div);
        n_v  = quot;
        if (quot < CMP_W'(i_cfg.snap_low_level)) begin
            n_v = '0;
        end
        if (n_v > CMP_W'(i_cfg.snap_high_level)) begin
            n_v = FULL_SCALE;
        end
    end

    always_comb begin
        old_w = CMP_W'(r_old);
        delta = (r_v >= old_w) ? (r_v - old_w) : (old_w - r_v);
        n_pos = (delta < CMP_W'(i_cfg.deadband_width)) ? r_old : r_v[fpc_pkg::POS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx    <= i_fader_index;
            r_sample <= i_filtered_sample;
        end
        if (i_cmd.prep) begin
            r_rem   <= num[NUM_W-1:SAMPLE_BITS];
            r_div   <= num[SAMPLE_BITS-1:0];
            r_span  <= i_cfg.travel_hi - i_cfg.travel_lo;
            r_empty <= (i_cfg.travel_hi <= i_cfg.travel_lo);
            r_old   <= r_slot_valid[slot] ? r_mem[slot] : '0;
        end
        if (i_cmd.step) begin
            r_rem <= trial_ge ? fpc_pkg::SMP_W'(trial - {1'b0, r_span})
                              : trial[fpc_pkg::SMP_W-1:0];
            r_div <= {r_div[SAMPLE_BITS-2:0], trial_ge};
        end
        if (i_cmd.snap) begin
            r_v <= n_v;
        end
        if (i_cmd.update) begin
            r_mem[slot] <= n_pos;
            r_out_idx   <= r_idx;
            r_out_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                r_slot_valid[slot] <= 1'b1;
                r_out_valid        <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_fader_index = r_out_idx;
    assign o_position        = r_out_pos;

endmodule

>>> design/fader_position_conditioner_top.sv
// Top level of the fader position conditioner: register port, controller and datapath.
`timescale 1ns / 1ps

// The block takes one transaction of a fader index and a filtered ADC sample,
// clamps the sample to the usable travel, rescales it to 0..2^SAMPLE_BITS-1 with
// truncating division, snaps it to zero or full scale at the snap levels, holds
// the fader's stored position when the change is below the deadband width, and
// then stores and emits the 12-bit position. A sample for a fader at or above
// active_faders (or at or above FADER_SLOTS) is consumed and produces no result.
// One transaction is worked on at a time: an accepted item goes through prepare,
// the restoring divider (which retires one quotient bit per cycle), snap and
// update before the next item is accepted; a dropped item is consumed while the
// block stays idle. The result sits in an output register, so the next item is
// accepted while that result waits to be taken; only a second finished result
// stalls the block until the first one leaves.
// Stored positions read as zero after reset until a fader is first updated.
// Registers sit at byte addresses 0, 4, 8, 12, 16 and 20 in the order lower travel
// limit, upper travel limit, snap_low_level, snap_high_level, deadband_width and
// active_faders; the user must write them only while the block is idle (not enforced).

module fader_position_conditioner_top #(
    parameter int FADER_SLOTS = fpc_pkg::FADER_SLOTS_DEF,
    parameter int SAMPLE_BITS = fpc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fpc_pkg::ADDR_W-1:0]  paddr,
    input  logic [fpc_pkg::DATA_W-1:0]  pwdata,
    output logic [fpc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // Sample input channel.
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [fpc_pkg::IDX_W-1:0]   i_fader_index,
    input  logic [fpc_pkg::SMP_W-1:0]   i_filtered_sample,
    // Position output channel.
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [fpc_pkg::IDX_W-1:0]   o_out_fader_index,
    output logic [fpc_pkg::POS_W-1:0]   o_position
);

    fpc_pkg::t_cfg       cfg;
    fpc_pkg::t_dp_cmd    dp_cmd;
    fpc_pkg::t_dp_status dp_status;

    // Configuration registers.
    fpc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The controller steps each transaction through prepare, divide, snap and
    // update, and holds the update while the output register is still full.
    fpc_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // The datapath holds the arithmetic, the per-fader position store and the
    // output register.
    fpc_datapath #(
        .FADER_SLOTS (FADER_SLOTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_status          (dp_status),
        .i_cfg             (cfg),
        .i_fader_index     (i_fader_index),
        .i_filtered_sample (i_filtered_sample),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_out_fader_index (o_out_fader_index),
        .o_position        (o_position)
    );

endmodule
